[rtl/tlc_pkg.sv]
// Shared types, constants and helper functions for the two-way traffic light controller.
package tlc_pkg;

    // Timing constants
    localparam int unsigned TICKS_PER_SECOND = 100;
    localparam int unsigned BLINK_HALF_TICKS = 50;

    // Field widths
    localparam int unsigned SECS_W  = 7;
    localparam int unsigned COUNT_W = 14;
    localparam int unsigned BLINK_W = $clog2(BLINK_HALF_TICKS + 1);
    localparam int unsigned IN_W    = 8;
    localparam int unsigned OUT_W   = 48;

    // Configuration register indexes
    localparam logic [1:0] CFG_RED    = 2'd0;
    localparam logic [1:0] CFG_YELLOW = 2'd1;
    localparam logic [1:0] CFG_GREEN  = 2'd2;

    typedef enum logic [1:0] {
        COL_RED    = 2'd0,
        COL_YELLOW = 2'd1,
        COL_GREEN  = 2'd2
    } t_colour;

    typedef enum logic [2:0] {
        MODE_NORMAL      = 3'd0,
        MODE_EDIT_RED    = 3'd1,
        MODE_EDIT_YELLOW = 3'd2,
        MODE_EDIT_GREEN  = 3'd3,
        MODE_INIT        = 3'd4
    } t_mode;

    // Durations in seconds, slot 0 red, 1 yellow, 2 green
    typedef logic [2:0][SECS_W-1:0] t_secs3;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [5:0]         pad;
        logic [SECS_W-1:0]  edit_seconds;
        logic [COUNT_W-1:0] remaining_two;
        logic [COUNT_W-1:0] remaining_one;
        logic [1:0]         mode_code;
        logic               lamps_lit;
        logic [1:0]         light_two;
        logic [1:0]         light_one;
    } t_result;

    // Seconds to ticks
    function automatic logic [COUNT_W-1:0] dur_ticks(input logic [SECS_W-1:0] secs);
        return COUNT_W'(COUNT_W'(secs) * COUNT_W'(TICKS_PER_SECOND));
    endfunction

    // Pick the stored duration for a colour
    function automatic logic [SECS_W-1:0] pick_secs(input t_secs3 ps, input t_colour col);
        logic [SECS_W-1:0] v;
        case (col)
            COL_RED:    v = ps[0];
            COL_YELLOW: v = ps[1];
            COL_GREEN:  v = ps[2];
            default:    v = ps[0];
        endcase
        return v;
    endfunction

    // Normal cycle order: red, green, yellow
    function automatic t_colour next_colour(input t_colour col);
        t_colour c;
        case (col)
            COL_RED:    c = COL_GREEN;
            COL_GREEN:  c = COL_YELLOW;
            COL_YELLOW: c = COL_RED;
            default:    c = col;
        endcase
        return c;
    endfunction

    // Add one second, 99 wraps to 0 (values above 99 reduced modulo 100)
    function automatic logic [SECS_W-1:0] edit_inc(input logic [SECS_W-1:0] v);
        logic [SECS_W:0] s;
        s = {1'b0, v} + (SECS_W+1)'(1);
        if (s >= (SECS_W+1)'(100)) begin
            s = s - (SECS_W+1)'(100);
        end
        return SECS_W'(s);
    endfunction

endpackage

[rtl/two_way_traffic_light_controller.sv]
// Top level of the two-way traffic light controller with duration editing.
//
//  channel  | direction | item                         | handshake
//  ---------+-----------+------------------------------+----------------------------
//  s        | in        | one tick with button pulses  | i_s_tvalid / o_s_tready
//  m        | out       | lamp colours, mode, timers   | o_m_tvalid / i_m_tready
//  cfg      | in        | initial duration write       | i_cfg_valid / o_cfg_ready
//
//  One item per cycle while o_s_tready is high: the whole tick update is done in the cycle
//  the item is accepted, and its result goes to the output register or, if stalled, the skid.
//  A two-entry output stage (result register plus skid) lets a new item in while a
//  result still waits; o_s_tready drops only when both entries are full.
//  Reset is synchronous; the first item after reset loads the durations from the
//  configuration registers and starts normal mode. Configuration writes are always taken.
module two_way_traffic_light_controller
    import tlc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [0] press_mode, [1] press_increment,
                                          // [2] press_store, [7:3] zero
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,   // [1:0] light_one, [3:2] light_two,
                                          // [4] lamps_lit, [6:5] mode_code,
                                          // [20:7] remaining_one, [34:21] remaining_two,
                                          // [41:35] edit_seconds, [47:42] zero
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [SECS_W-1:0] i_cfg_data
);

    // Controller state
    t_mode               r_mode,  n_mode;
    t_colour             r_col1,  n_col1;
    t_colour             r_col2,  n_col2;
    logic [COUNT_W-1:0]  r_cnt1,  n_cnt1;
    logic [COUNT_W-1:0]  r_cnt2,  n_cnt2;
    logic                r_exp1,  n_exp1;
    logic                r_exp2,  n_exp2;
    logic                r_expb,  n_expb;
    logic [BLINK_W-1:0]  r_blink, n_blink;
    logic                r_lamp,  n_lamp;
    t_secs3              r_ps,    n_ps;
    logic [SECS_W-1:0]   r_edit,  n_edit;
    t_secs3              r_cfg;

    // Output stage
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    t_result n_res;

    logic in_acc;
    logic b_mode, b_inc, b_store;
    logic [1:0] slot;

    assign b_mode  = i_s_tdata[0];
    assign b_inc   = i_s_tdata[1];
    assign b_store = i_s_tdata[2];

    assign o_s_tready  = !r_skid_valid;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out;
    assign o_cfg_ready = 1'b1;

    assign slot = 2'(r_mode[1:0] - 2'd1);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= SECS_W'(5);
            r_cfg[1] <= SECS_W'(2);
            r_cfg[2] <= SECS_W'(3);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RED:    r_cfg[0] <= i_cfg_data;
                CFG_YELLOW: r_cfg[1] <= i_cfg_data;
                CFG_GREEN:  r_cfg[2] <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Tick update: timers count down first, then the mode logic
    always_comb begin
        n_mode  = r_mode;
        n_col1  = r_col1;
        n_col2  = r_col2;
        n_cnt1  = r_cnt1;
        n_cnt2  = r_cnt2;
        n_exp1  = r_exp1;
        n_exp2  = r_exp2;
        n_expb  = r_expb;
        n_blink = r_blink;
        n_lamp  = r_lamp;
        n_ps    = r_ps;
        n_edit  = r_edit;

        if (r_cnt1 != '0) begin
            n_cnt1 = r_cnt1 - COUNT_W'(1);
            if (n_cnt1 == '0) n_exp1 = 1'b1;
        end
        if (r_cnt2 != '0) begin
            n_cnt2 = r_cnt2 - COUNT_W'(1);
            if (n_cnt2 == '0) n_exp2 = 1'b1;
        end
        if (r_blink != '0) begin
            n_blink = r_blink - BLINK_W'(1);
            if (n_blink == '0) n_expb = 1'b1;
        end

        case (r_mode)
            MODE_NORMAL: begin
                if (n_exp1) begin
                    n_col1 = next_colour(r_col1);
                    n_cnt1 = dur_ticks(pick_secs(r_ps, n_col1));
                    n_exp1 = (n_cnt1 == '0);
                end
                if (n_exp2) begin
                    n_col2 = next_colour(r_col2);
                    n_cnt2 = dur_ticks(pick_secs(r_ps, n_col2));
                    n_exp2 = (n_cnt2 == '0);
                end
                // into edit red, direction timers cleared
                if (b_mode) begin
                    n_cnt1  = '0;
                    n_cnt2  = '0;
                    n_exp1  = 1'b0;
                    n_exp2  = 1'b0;
                    n_col1  = COL_RED;
                    n_col2  = COL_RED;
                    n_lamp  = 1'b1;
                    n_blink = BLINK_W'(BLINK_HALF_TICKS);
                    n_expb  = 1'b0;
                    n_edit  = r_ps[0];
                    n_mode  = MODE_EDIT_RED;
                end
            end
            MODE_EDIT_RED, MODE_EDIT_YELLOW, MODE_EDIT_GREEN: begin
                // blink toggle
                if (n_expb) begin
                    n_lamp  = !r_lamp;
                    n_blink = BLINK_W'(BLINK_HALF_TICKS);
                    n_expb  = 1'b0;
                end
                if (b_inc) n_edit = edit_inc(r_edit);
                if (b_store) n_ps[slot] = n_edit;
                if (b_mode) begin
                    if (r_mode == MODE_EDIT_GREEN) begin
                        // back to normal with the edited durations
                        n_blink = '0;
                        n_expb  = 1'b0;
                        n_col1  = COL_RED;
                        n_col2  = COL_GREEN;
                        n_lamp  = 1'b1;
                        n_cnt1  = dur_ticks(n_ps[0]);
                        n_exp1  = (n_cnt1 == '0);
                        n_cnt2  = dur_ticks(n_ps[2]);
                        n_exp2  = (n_cnt2 == '0);
                        n_mode  = MODE_NORMAL;
                    end else begin
                        n_col1  = t_colour'(r_mode[1:0]);
                        n_col2  = t_colour'(r_mode[1:0]);
                        n_lamp  = 1'b1;
                        n_blink = BLINK_W'(BLINK_HALF_TICKS);
                        n_expb  = 1'b0;
                        n_edit  = n_ps[r_mode[1:0]];
                        n_mode  = t_mode'(r_mode + 3'd1);
                    end
                end
            end
            default: begin
                // initialisation: take durations and start normal mode
                n_ps   = r_cfg;
                n_col1 = COL_RED;
                n_col2 = COL_GREEN;
                n_lamp = 1'b1;
                n_cnt1 = dur_ticks(r_cfg[0]);
                n_exp1 = (n_cnt1 == '0);
                n_cnt2 = dur_ticks(r_cfg[2]);
                n_exp2 = (n_cnt2 == '0);
                n_mode = MODE_NORMAL;
            end
        endcase
    end

    // Result of the item being accepted
    always_comb begin
        n_res               = '0;
        n_res.light_one     = n_col1;
        n_res.light_two     = n_col2;
        n_res.lamps_lit     = n_lamp;
        n_res.mode_code     = n_mode[1:0];
        n_res.remaining_one = n_cnt1;
        n_res.remaining_two = n_cnt2;
        n_res.edit_seconds  = n_edit;
    end

    // State registers, advanced once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_INIT;
            r_col1  <= COL_RED;
            r_col2  <= COL_GREEN;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_exp1  <= 1'b0;
            r_exp2  <= 1'b0;
            r_expb  <= 1'b0;
            r_blink <= '0;
            r_lamp  <= 1'b1;
            r_ps    <= '0;
            r_edit  <= '0;
        end else if (in_acc) begin
            r_mode  <= n_mode;
            r_col1  <= n_col1;
            r_col2  <= n_col2;
            r_cnt1  <= n_cnt1;
            r_cnt2  <= n_cnt2;
            r_exp1  <= n_exp1;
            r_exp2  <= n_exp2;
            r_expb  <= n_expb;
            r_blink <= n_blink;
            r_lamp  <= n_lamp;
            r_ps    <= n_ps;
            r_edit  <= n_edit;
        end
    end

    // Output register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || i_m_tready) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid  <= in_acc;
                end
            end else if (in_acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

endmodule

[rtl/tlc_checker.sv]
// Port-level checker for the traffic light controller, bound to the top level.
module tlc_checker
    import tlc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Input back-pressure only with a result waiting
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // Edit modes: both lights agree and the timers are cleared
    a_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[6:5] != 2'(MODE_NORMAL)) |->
            (o_m_tdata[1:0] == o_m_tdata[3:2]) && (o_m_tdata[34:7] == 28'd0))
        else $error("edit mode result inconsistent");

    // Normal mode: lamps steadily on
    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[6:5] == 2'(MODE_NORMAL)) |-> o_m_tdata[4])
        else $error("normal mode result inconsistent");

endmodule

bind two_way_traffic_light_controller tlc_checker u_tlc_checker (.*);
